>>> rtl/tvec_pkg.sv
package tvec_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [31:0] WINDOW_MS   = 32'd2500;
    localparam logic [31:0] COOLDOWN_MS = 32'd3000;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;
    // the action map holds two bits for each of the first sixteen classes
    localparam int unsigned MAP_CLASSES = 16;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ENABLE       = 3'd0;
    localparam cfg_idx_t CFG_REQ_VOTES    = 3'd1;
    localparam cfg_idx_t CFG_BAND_CENTER  = 3'd2;
    localparam cfg_idx_t CFG_BAND_TOL     = 3'd3;
    localparam cfg_idx_t CFG_REPEAT_COUNT = 3'd4;
    localparam cfg_idx_t CFG_CLASS_COUNT  = 3'd5;
    localparam cfg_idx_t CFG_ACTION_MAP   = 3'd6;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_PULL  = 1'b1;

    typedef logic [1:0] action_t;
    localparam action_t ACT_NONE = 2'd0;

    typedef struct packed {
        logic        op;
        logic [31:0] time_ms;
        logic        box_found;
        logic [8:0]  box_top;
        logic [8:0]  box_height;
        logic        shape_ok;
        logic [7:0]  pred_class;
    } item_t;

    typedef struct packed {
        logic        entered;
        logic        recognizing;
        logic        decided;
        logic [3:0]  decided_class;
        action_t     decided_action;
        logic [7:0]  vote_total;
        logic        tx_valid;
        action_t     tx_action;
        logic [7:0]  tx_seq;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLEAR,
        ST_VOTE_RD,
        ST_VOTE_WR,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic enter;
        logic clear_step;
        logic vote_rd;
        logic vote_wr;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go_enter;
        logic go_recog;
        logic do_vote;
        logic close;
        logic clear_last;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

>>> rtl/tvec_if.sv
interface tvec_item_if;
    import tvec_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvec_result_if;
    import tvec_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tvec_ctrl.sv
module tvec_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tvec_pkg::status_t status,
    output tvec_pkg::cmd_t    cmd
);
    import tvec_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.go_enter)
                begin
                    cmd.enter  = 1'b1;
                    state_next = ST_CLEAR;
                end
                else if (status.go_recog)
                begin
                    state_next = status.do_vote ? ST_VOTE_RD : ST_CHECK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_VOTE_RD:
            begin
                cmd.vote_rd = 1'b1;
                state_next  = ST_VOTE_WR;
            end
            ST_VOTE_WR:
            begin
                cmd.vote_wr = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.close)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tvec_dp.sv
module tvec_dp #(
    parameter int unsigned MAX_CLASSES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  tvec_pkg::cfg_idx_t                cfg_index,
    input  logic [tvec_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tvec_pkg::item_t                   item_data,
    input  logic                              result_ready,
    output logic                              result_valid,
    output tvec_pkg::result_t                 result_data,
    input  tvec_pkg::cmd_t                    cmd,
    output tvec_pkg::status_t                 status
);
    import tvec_pkg::*;

    localparam int unsigned IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_CLASSES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLASSES - 1);

    // configuration
    logic        cfg_enable_reg;
    logic [7:0]  cfg_req_reg;
    logic [8:0]  cfg_center_reg;
    logic [8:0]  cfg_tol_reg;
    logic [7:0]  cfg_rep_reg;
    logic [4:0]  cfg_ccount_reg;
    logic [31:0] cfg_map_reg;

    // controller state
    item_t       item_reg;
    logic        mode_reg, mode_next;
    logic        armed_reg, armed_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] cooldown_reg, cooldown_next;
    logic [7:0]  votes_reg, votes_next;
    logic [7:0]  next_seq_reg, next_seq_next;
    action_t     pend_act_reg, pend_act_next;
    logic [7:0]  pend_seq_reg, pend_seq_next;
    logic [7:0]  pend_rep_reg, pend_rep_next;

    result_t     res_reg, res_next;
    result_t     out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;

    // histogram sweep and scan
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [7:0]       best_cnt_reg, best_cnt_next;
    logic             have_reg, have_next;

    logic [7:0]       votes_mem [MAX_CLASSES];
    logic [7:0]       mem_q;
    logic [IDX_W-1:0] mem_ra;
    logic [IDX_W-1:0] mem_wa;
    logic [7:0]       mem_wd;
    logic             mem_we;

    logic [CNT_W-1:0] n_classes;
    logic [9:0]       centre;
    logic             in_band;
    logic             frame_live;
    logic             past_cool;
    logic [IDX_W-1:0] pred_idx;
    logic             pred_valid;
    logic             scan_issue;
    logic [3:0]       win_cls;
    action_t          win_act;

    assign n_classes = (32'(cfg_ccount_reg) < MAX_CLASSES) ? CNT_W'(cfg_ccount_reg) : MAX_CNT;
    assign centre    = 10'(item_reg.box_top) + 10'(item_reg.box_height >> 1);
    assign in_band   = (11'(centre) + 11'(cfg_tol_reg) >= 11'(cfg_center_reg))
                    && (11'(centre) <= 11'(cfg_center_reg) + 11'(cfg_tol_reg));
    assign frame_live = (item_reg.op == OP_FRAME) && cfg_enable_reg;
    assign past_cool  = item_reg.time_ms >= cooldown_reg;
    assign pred_idx   = IDX_W'(item_reg.pred_class);
    assign pred_valid = 32'(item_reg.pred_class) < 32'(n_classes);
    assign scan_issue = cmd.scan_step && (scan_cnt_reg < n_classes);

    assign win_cls = 4'(best_reg);
    assign win_act = (have_reg && (32'(best_reg) < MAP_CLASSES))
                   ? cfg_map_reg[{win_cls, 1'b0} +: 2] : ACT_NONE;

    always_comb
    begin
        status.go_enter   = frame_live && !mode_reg && past_cool && item_reg.box_found
                         && armed_reg && in_band && item_reg.shape_ok;
        status.go_recog   = frame_live && mode_reg;
        status.do_vote    = frame_live && mode_reg && item_reg.box_found && pred_valid;
        status.close      = (votes_reg >= cfg_req_reg) || (item_reg.time_ms >= deadline_reg);
        status.clear_last = clr_cnt_reg == LAST_IDX;
        status.scan_done  = (scan_cnt_reg == n_classes) && !rd_pend_reg;
        status.out_free   = !out_valid_reg || result_ready;
    end

    // histogram memory: one write port, one registered read port
    always_comb
    begin
        mem_ra = cmd.vote_rd ? pred_idx : scan_cnt_reg[IDX_W-1:0];
        mem_we = cmd.clear_step || cmd.vote_wr;
        mem_wa = cmd.clear_step ? clr_cnt_reg : pred_idx;
        mem_wd = cmd.clear_step ? 8'd0
               : ((mem_q == COUNT_MAX) ? COUNT_MAX : mem_q + 8'd1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            votes_mem[mem_wa] <= mem_wd;
        end
        mem_q <= votes_mem[mem_ra];
    end

    always_comb
    begin
        mode_next      = mode_reg;
        armed_next     = armed_reg;
        deadline_next  = deadline_reg;
        cooldown_next  = cooldown_reg;
        votes_next     = votes_reg;
        next_seq_next  = next_seq_reg;
        pend_act_next  = pend_act_reg;
        pend_seq_next  = pend_seq_reg;
        pend_rep_next  = pend_rep_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_cnt_next  = best_cnt_reg;
        have_next      = have_reg;

        if (cmd.load)
        begin
            res_next     = '0;
            clr_cnt_next = '0;
        end

        if (cmd.eval)
        begin
            if (item_reg.op == OP_PULL)
            begin
                if (pend_act_reg != ACT_NONE && pend_rep_reg != 8'd0)
                begin
                    res_next.tx_valid  = 1'b1;
                    res_next.tx_action = pend_act_reg;
                    res_next.tx_seq    = pend_seq_reg;
                    pend_rep_next      = pend_rep_reg - 8'd1;
                    if (pend_rep_reg == 8'd1)
                    begin
                        pend_act_next = ACT_NONE;
                    end
                end
            end
            else if (frame_live && !mode_reg && past_cool && !item_reg.box_found)
            begin
                armed_next = 1'b1;
            end
        end

        if (cmd.enter)
        begin
            mode_next        = 1'b1;
            votes_next       = 8'd0;
            deadline_next    = item_reg.time_ms + WINDOW_MS;
            res_next.entered = 1'b1;
        end

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + IDX_W'(1);
        end

        if (cmd.vote_wr && votes_reg != COUNT_MAX)
        begin
            votes_next = votes_reg + 8'd1;
        end

        if (cmd.scan_start)
        begin
            scan_cnt_next = '0;
            rd_pend_next  = 1'b0;
            have_next     = 1'b0;
            best_next     = '0;
            best_cnt_next = 8'd0;
        end

        if (cmd.scan_step)
        begin
            // issue the next read and fold in the one that came back
            rd_pend_next = scan_issue;
            if (scan_issue)
            begin
                rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            // strict compare keeps the first class among equal counts
            if (rd_pend_reg && (!have_reg || mem_q > best_cnt_reg))
            begin
                have_next     = 1'b1;
                best_next     = rd_idx_reg;
                best_cnt_next = mem_q;
            end
        end

        if (cmd.decide)
        begin
            res_next.decided        = 1'b1;
            res_next.decided_class  = have_reg ? win_cls : 4'd0;
            res_next.decided_action = win_act;
            if (win_act != ACT_NONE)
            begin
                pend_act_next = win_act;
                pend_seq_next = next_seq_reg;
                next_seq_next = next_seq_reg + 8'd1;
                pend_rep_next = cfg_rep_reg;
                armed_next    = 1'b0;
            end
            mode_next     = 1'b0;
            cooldown_next = item_reg.time_ms + COOLDOWN_MS;
        end

        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_data_next             = res_reg;
            out_data_next.recognizing = mode_reg;
            out_data_next.vote_total  = votes_reg;
            out_valid_next            = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_data;
        end
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_enable_reg <= 1'b0;
            cfg_req_reg    <= 8'd8;
            cfg_center_reg <= 9'd240;
            cfg_tol_reg    <= 9'd60;
            cfg_rep_reg    <= 8'd3;
            cfg_ccount_reg <= 5'd3;
            cfg_map_reg    <= 32'd36;
            mode_reg       <= 1'b0;
            armed_reg      <= 1'b1;
            deadline_reg   <= 32'd0;
            cooldown_reg   <= 32'd0;
            votes_reg      <= 8'd0;
            next_seq_reg   <= 8'd0;
            pend_act_reg   <= ACT_NONE;
            pend_seq_reg   <= 8'd0;
            pend_rep_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            have_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_ENABLE:       cfg_enable_reg <= cfg_data[0];
                    CFG_REQ_VOTES:    cfg_req_reg    <= cfg_data[7:0];
                    CFG_BAND_CENTER:  cfg_center_reg <= cfg_data[8:0];
                    CFG_BAND_TOL:     cfg_tol_reg    <= cfg_data[8:0];
                    CFG_REPEAT_COUNT: cfg_rep_reg    <= cfg_data[7:0];
                    CFG_CLASS_COUNT:  cfg_ccount_reg <= cfg_data[4:0];
                    CFG_ACTION_MAP:   cfg_map_reg    <= cfg_data[31:0];
                    default:          ;
                endcase
            end
            mode_reg      <= mode_next;
            armed_reg     <= armed_next;
            deadline_reg  <= deadline_next;
            cooldown_reg  <= cooldown_next;
            votes_reg     <= votes_next;
            next_seq_reg  <= next_seq_next;
            pend_act_reg  <= pend_act_next;
            pend_seq_reg  <= pend_seq_next;
            pend_rep_reg  <= pend_rep_next;
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            have_reg      <= have_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

>>> rtl/trigger_vote_event_controller_core.sv
// Trigger and vote controller: a frame transfer (op = 0) may open a recognition window
// when the block is enabled, armed, past its cooldown, shape_ok is set and the box centre
// row sits in the configured band; later frames vote into a per-class histogram until the
// required vote count or the 2500 ms deadline closes the window, the first most-voted class
// is mapped to an action, and a nonzero action is queued for pull transfers (op = 1) with a
// wrapping sequence number and a repeat count. One item is handled at a time and each item
// gives exactly one result. An entry frame clears all MAX_CLASSES histogram counters (the
// clear sweeps one counter per cycle through its single write port); a closing frame scans
// the first n = min(class_count, MAX_CLASSES) counters for the winner (the scan reads one
// counter per cycle from the histogram memory). A new item is taken while the previous
// result still waits in the output register. Configuration writes are taken at any edge
// with cfg_write_en high; write them only while no item is in flight.
module trigger_vote_event_controller_core #(
    parameter int unsigned MAX_CLASSES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  tvec_pkg::cfg_idx_t              cfg_index,
    input  logic [tvec_pkg::CFG_DATA_W-1:0] cfg_data,
    tvec_item_if.sink                       item,
    tvec_result_if.source                   result
);
    import tvec_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: steps one item through eval, clear, vote, scan and decide
    tvec_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // state registers, config, histogram memory and output register
    tvec_dp #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_data    (item.data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_data  (result.data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tvec_pkg::*;

    localparam int unsigned N_CLASS_SLOTS = 16;
    localparam logic [31:0] WINDOW_LEN_MS = 32'd2500;
    localparam logic [31:0] HOLDOFF_MS    = 32'd3000;
    localparam int          N_SETTINGS    = 10;
    localparam int          ITEMS_PER_SET = 60;
    localparam int          SETTLE_CYCLES = 40;

    // ------------------------------------------------------------------
    // Clock, reset and the channels
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    logic                  cfg_write_en = 1'b0;
    cfg_idx_t              cfg_index    = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic  drv_valid  = 1'b0;
    item_t drv_data   = '0;
    logic  sink_ready = 1'b0;

    tvec_item_if   item_ch ();
    tvec_result_if result_ch ();

    assign item_ch.valid   = drv_valid;
    assign item_ch.data    = drv_data;
    assign result_ch.ready = sink_ready;

    trigger_vote_event_controller_core #(
        .MAX_CLASSES (N_CLASS_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item_ch),
        .result       (result_ch)
    );

    // ------------------------------------------------------------------
    // Controller shadow: register copies (reset values) and state
    // ------------------------------------------------------------------
    logic        set_enable     = 1'b0;
    logic [7:0]  set_req_votes  = 8'd8;
    logic [8:0]  set_band_ctr   = 9'd240;
    logic [8:0]  set_band_tol   = 9'd60;
    logic [7:0]  set_repeats    = 8'd3;
    logic [4:0]  set_classes    = 5'd3;
    logic [31:0] set_action_map = 32'd36;

    logic        rec_mode        = 1'b0;
    logic        armed           = 1'b1;
    logic [31:0] deadline_ms     = '0;
    logic [31:0] cooldown_end_ms = '0;
    logic [7:0]  vote_count      = '0;
    logic [7:0]  class_hist [N_CLASS_SLOTS] = '{default: 8'd0};
    logic [7:0]  seq_next        = '0;
    action_t     pend_action     = ACT_NONE;
    logic [7:0]  pend_seq        = '0;
    logic [7:0]  pend_left       = '0;

    // Stimulus and scoreboard storage
    item_t   items_to_send [$];
    result_t expected_outcomes [$];
    logic    item_fire = 1'b0;   // input transfer seen at the last rising edge

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int queued_count   = 0;
    int error_count    = 0;
    int items_in       = 0;
    int windows_opened = 0;
    int windows_closed = 0;
    int events_out     = 0;

    logic [31:0] gen_ms = '0;     // timestamp of the next generated frame

    function automatic int valid_classes();
        return (set_classes < N_CLASS_SLOTS) ? int'(set_classes) : int'(N_CLASS_SLOTS);
    endfunction

    // One item through the controller: updates the shadow, returns the result.
    task automatic step_controller(input item_t it, output result_t r);
        int n;
        int centre;
        int lo;
        int hi;
        int best;
        int best_n;
        logic have;
        r = '0;
        if (it.op == OP_PULL) begin
            if (pend_action != ACT_NONE && pend_left != 0) begin
                r.tx_valid  = 1'b1;
                r.tx_action = pend_action;
                r.tx_seq    = pend_seq;
                pend_left--;
                if (pend_left == 0)
                    pend_action = ACT_NONE;
            end
        end else if (set_enable) begin
            if (!rec_mode) begin
                if (it.time_ms >= cooldown_end_ms) begin
                    if (!it.box_found) begin
                        armed = 1'b1;
                    end else if (armed) begin
                        centre = int'(it.box_top) + int'(it.box_height) / 2;
                        lo = int'(set_band_ctr) - int'(set_band_tol);
                        hi = int'(set_band_ctr) + int'(set_band_tol);
                        if (centre >= lo && centre <= hi && it.shape_ok) begin
                            rec_mode    = 1'b1;
                            class_hist  = '{default: 8'd0};
                            vote_count  = '0;
                            deadline_ms = it.time_ms + WINDOW_LEN_MS;
                            r.entered   = 1'b1;
                        end
                    end
                end
            end else begin
                n = valid_classes();
                if (it.box_found && int'(it.pred_class) < n) begin
                    if (class_hist[it.pred_class] != 8'hFF)
                        class_hist[it.pred_class]++;
                    if (vote_count != 8'hFF)
                        vote_count++;
                end
                if (vote_count >= set_req_votes || it.time_ms >= deadline_ms) begin
                    // first class with the highest count wins
                    have   = 1'b0;
                    best   = 0;
                    best_n = 0;
                    for (int i = 0; i < n; i++) begin
                        if (!have || int'(class_hist[i]) > best_n) begin
                            have   = 1'b1;
                            best   = i;
                            best_n = int'(class_hist[i]);
                        end
                    end
                    r.decided = 1'b1;
                    if (have) begin
                        r.decided_class  = best[3:0];
                        r.decided_action = set_action_map[2*best +: 2];
                    end
                    if (r.decided_action != ACT_NONE) begin
                        pend_action = r.decided_action;
                        pend_seq    = seq_next;
                        seq_next++;
                        pend_left   = set_repeats;
                        armed       = 1'b0;
                    end
                    rec_mode        = 1'b0;
                    cooldown_end_ms = it.time_ms + HOLDOFF_MS;
                end
            end
        end
        r.recognizing = rec_mode;
        r.vote_total  = vote_count;
    endtask

    // ------------------------------------------------------------------
    // Driver: items at the falling edge, receiver stalls likewise
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!drv_valid || item_fire) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_data  <= items_to_send.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
            sink_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, compare on output transfers
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        result_t got;
        item_fire = rst_n && item_ch.valid && item_ch.ready;
        if (item_fire) begin
            step_controller(item_ch.data, want);
            expected_outcomes.insert(expected_outcomes.size(), want);
            items_in++;
            windows_opened += int'(want.entered);
            windows_closed += int'(want.decided);
            events_out     += int'(want.tx_valid);
        end
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (expected_outcomes.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, actual %h", $time, got);
            end else begin
                want = expected_outcomes.pop_front();
                check_field("entered", 32'(want.entered), 32'(got.entered));
                check_field("recognizing", 32'(want.recognizing), 32'(got.recognizing));
                check_field("decided", 32'(want.decided), 32'(got.decided));
                check_field("decided_class", 32'(want.decided_class),
                            32'(got.decided_class));
                check_field("decided_action", 32'(want.decided_action),
                            32'(got.decided_action));
                check_field("vote_total", 32'(want.vote_total), 32'(got.vote_total));
                check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
                check_field("tx_action", 32'(want.tx_action), 32'(got.tx_action));
                check_field("tx_seq", 32'(want.tx_seq), 32'(got.tx_seq));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t build_item(input logic op, input logic [31:0] t_ms,
                                         input logic found, input logic [8:0] top,
                                         input logic [8:0] h, input logic shape,
                                         input logic [7:0] pred);
        item_t it;
        it.op         = op;
        it.time_ms    = t_ms;
        it.box_found  = found;
        it.box_top    = top;
        it.box_height = h;
        it.shape_ok   = shape;
        it.pred_class = pred;
        return it;
    endfunction

    task automatic send(input item_t it);
        items_to_send.insert(items_to_send.size(), it);
        queued_count++;
    endtask

    // pull with every other field random
    function automatic item_t pull_item();
        return build_item(OP_PULL, $urandom, 1'($urandom_range(1)),
                          9'($urandom_range(511)), 9'($urandom_range(511)),
                          1'($urandom_range(1)), 8'($urandom_range(255)));
    endfunction

    // top row that puts the box centre inside the current band, if one exists
    function automatic logic [8:0] band_top(input logic [8:0] h);
        int half;
        int lo;
        int hi;
        half = int'(h) / 2;
        lo = int'(set_band_ctr) - int'(set_band_tol);
        hi = int'(set_band_ctr) + int'(set_band_tol);
        if (lo < half)
            lo = half;
        if (hi > 511 + half)
            hi = 511 + half;
        if (lo > hi)
            return 9'($urandom_range(511));
        return 9'(int'($urandom_range(hi, lo)) - half);
    endfunction

    // arm, enter, vote until the window should close, then pull
    task automatic queue_episode();
        int n_votes;
        int n;
        logic [31:0] step_max;
        logic [8:0]  h;
        logic [7:0]  pred;
        n = valid_classes();
        step_max = (set_req_votes > 40) ? 32'd4 : 32'd400;
        if ($urandom_range(99) < 85)
            gen_ms += HOLDOFF_MS + $urandom_range(600);
        else
            gen_ms += $urandom_range(800);
        send(build_item(OP_FRAME, gen_ms, 1'b0, 9'($urandom_range(511)),
                        9'($urandom_range(511)), 1'($urandom_range(1)),
                        8'($urandom_range(255))));
        repeat ($urandom_range(2))
            send(pull_item());
        gen_ms += $urandom_range(50);
        h = 9'($urandom_range(480, 1));
        if ($urandom_range(99) < 85)
            send(build_item(OP_FRAME, gen_ms, 1'b1, band_top(h), h, 1'b1,
                            8'($urandom_range(255))));
        else
            send(build_item(OP_FRAME, gen_ms, 1'b1, 9'($urandom_range(511)), h,
                            1'($urandom_range(1)), 8'($urandom_range(255))));
        n_votes = int'(set_req_votes) + int'($urandom_range(3));
        if (set_req_votes > 40)
            n_votes += int'(set_req_votes) / 4;
        repeat (n_votes) begin
            gen_ms += $urandom_range(step_max);
            if (n > 0 && $urandom_range(99) < 88)
                pred = 8'($urandom_range(n - 1));
            else
                pred = 8'($urandom_range(255));
            h = 9'($urandom_range(511));
            send(build_item(OP_FRAME, gen_ms, $urandom_range(99) < 93,
                            9'($urandom_range(511)), h, 1'($urandom_range(1)), pred));
        end
        repeat ($urandom_range(4))
            send(pull_item());
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = val;
        case (idx)
            CFG_ENABLE:       set_enable     = val[0];
            CFG_REQ_VOTES:    set_req_votes  = val[7:0];
            CFG_BAND_CENTER:  set_band_ctr   = val[8:0];
            CFG_BAND_TOL:     set_band_tol   = val[8:0];
            CFG_REPEAT_COUNT: set_repeats    = val[7:0];
            CFG_CLASS_COUNT:  set_classes    = val[4:0];
            CFG_ACTION_MAP:   set_action_map = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // wait until every item went in and every result came out, then settle
    task automatic drain();
        while (items_to_send.size() != 0 || drv_valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] v_req;
        logic [31:0] v_ctr;
        logic [31:0] v_tol;
        logic [31:0] v_rep;
        logic [31:0] v_cc;
        logic [31:0] v_map;
        int budget;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings. Disabled: a frame in band is ignored,
        // a pull with nothing queued gives nothing.
        send(build_item(OP_FRAME, 32'd100, 1'b1, 9'd210, 9'd60, 1'b1, 8'd0));
        send(build_item(OP_PULL, 32'd100, 1'b0, 9'd0, 9'd0, 1'b0, 8'd0));
        drain();
        write_reg(CFG_ENABLE, 32'd1);

        send(build_item(OP_FRAME, 32'd100, 1'b0, 9'd0, 9'd1, 1'b0, 8'd0));     // arm
        send(build_item(OP_FRAME, 32'd110, 1'b1, 9'd210, 9'd60, 1'b1, 8'd1));  // entry, no vote
        send(build_item(OP_FRAME, 32'd120, 1'b1, 9'd0, 9'd1, 1'b0, 8'd0));
        send(build_item(OP_FRAME, 32'd130, 1'b1, 9'd0, 9'd1, 1'b0, 8'd3));     // past class_count
        send(build_item(OP_FRAME, 32'd140, 1'b1, 9'd0, 9'd1, 1'b0, 8'd255));
        send(build_item(OP_FRAME, 32'd150, 1'b0, 9'd0, 9'd1, 1'b0, 8'd1));     // no box, no vote
        repeat (7)
            send(build_item(OP_FRAME, 32'd160, 1'b1, 9'd0, 9'd1, 1'b0, 8'd2));
        // decided at 160: supply queued, disarmed, holdoff to 3160
        send(build_item(OP_FRAME, 32'd300, 1'b1, 9'd210, 9'd60, 1'b1, 8'd0));  // holdoff
        repeat (4)
            send(build_item(OP_PULL, 32'd300, 1'b0, 9'd0, 9'd0, 1'b0, 8'd0));
        send(build_item(OP_FRAME, 32'd3200, 1'b1, 9'd210, 9'd60, 1'b1, 8'd0)); // disarmed
        send(build_item(OP_FRAME, 32'd3300, 1'b0, 9'd0, 9'd1, 1'b0, 8'd0));    // re-arm
        send(build_item(OP_FRAME, 32'd3310, 1'b1, 9'd300, 9'd1, 1'b1, 8'd0));  // upper band edge
        send(build_item(OP_FRAME, 32'd5810, 1'b1, 9'd0, 9'd1, 1'b0, 8'd9));    // deadline
        send(build_item(OP_FRAME, 32'd8900, 1'b1, 9'd301, 9'd1, 1'b1, 8'd0));  // just outside
        send(build_item(OP_FRAME, 32'd8905, 1'b1, 9'd511, 9'd511, 1'b1, 8'd0));
        send(build_item(OP_FRAME, 32'd8910, 1'b1, 9'd180, 9'd1, 1'b1, 8'd0));  // lower edge
        drain();
        gen_ms = 32'd20000;

        // Random part: one register setting per phase, idling pattern rotates
        for (int k = 0; k < N_SETTINGS; k++) begin
            case (k)
                0: begin
                    v_req = 1;   v_ctr = 0;   v_tol = 0;   v_rep = 0;
                    v_cc  = 1;   v_map = 32'hFFFF_FFFF;
                end
                1: begin
                    v_req = 255; v_ctr = 479; v_tol = 479; v_rep = 255;
                    v_cc  = 16;  v_map = $urandom;
                end
                2: begin
                    v_req = 0;   v_ctr = 240; v_tol = 60;  v_rep = 3;
                    v_cc  = 0;   v_map = 32'd36;
                end
                3: begin
                    v_req = $urandom_range(12, 2); v_ctr = 511; v_tol = 511; v_rep = 1;
                    v_cc  = 31;  v_map = 32'd0;
                end
                default: begin
                    v_req = $urandom_range(12, 1);
                    v_ctr = $urandom_range(479);
                    v_tol = $urandom_range(200, 20);
                    v_rep = $urandom_range(5);
                    v_cc  = $urandom_range(16, 1);
                    v_map = $urandom;
                end
            endcase
            write_reg(CFG_ENABLE,       32'd1);
            write_reg(CFG_REQ_VOTES,    v_req);
            write_reg(CFG_BAND_CENTER,  v_ctr);
            write_reg(CFG_BAND_TOL,     v_tol);
            write_reg(CFG_REPEAT_COUNT, v_rep);
            write_reg(CFG_CLASS_COUNT,  v_cc);
            write_reg(CFG_ACTION_MAP,   v_map);

            case (k % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin send_idle_pct = 25; sink_stall_pct = 25; end
            endcase

            // deadline and holdoff end wrap past 2^32 in this phase
            if (k == 4)
                gen_ms = 32'hFFFF_F000 + $urandom_range(2000);

            budget = queued_count + ITEMS_PER_SET;
            while (queued_count < budget) begin
                if ($urandom_range(99) < 20) begin
                    repeat ($urandom_range(5, 1)) begin
                        gen_ms += $urandom_range(300);
                        send(build_item(1'($urandom_range(1)), gen_ms,
                                        1'($urandom_range(1)),
                                        9'($urandom_range(511)), 9'($urandom_range(511)),
                                        1'($urandom_range(1)), 8'($urandom_range(255))));
                    end
                end else begin
                    queue_episode();
                end
            end
            drain();
        end

        $display("covered %0d transfers over %0d register settings plus a directed part",
                 items_in, N_SETTINGS);
        $display("%0d windows opened, %0d closed, %0d events handed out",
                 windows_opened, windows_closed, events_out);
        if (error_count == 0)
            $display("trigger_vote_event_controller_core: match");
        else
            $display("trigger_vote_event_controller_core: mismatch");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #800000;
        $display("timeout at %0t", $time);
        $display("trigger_vote_event_controller_core: mismatch");
        $finish;
    end

endmodule
